// ----- hw/rtl/delayed_min_hold_meter_core_macros.svh -----
// Assertion macros for the delayed minimum-hold meter.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef DELAYED_MIN_HOLD_METER_CORE_MACROS_SVH
`define DELAYED_MIN_HOLD_METER_CORE_MACROS_SVH

// Same-cycle implication.
`define DMHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DMHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/dmhm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the delayed minimum-hold meter.
// No dependencies.
`timescale 1ns / 1ps

package dmhm_pkg;

  localparam int LEVEL_W = 16;
  localparam int STEP_W  = 12;

  localparam int DEF_DELAY_LEN    = 16;
  localparam int DEF_WINDOW_TICKS = 150;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 16'sh7FFF;
  localparam logic signed [LEVEL_W-1:0] CEIL_RESET  = 16'sh0000;
  localparam logic [STEP_W-1:0]         STEP_RESET  = 12'd85;

  // Register indexes of the configuration port
  localparam logic REG_CEILING = 1'b0;
  localparam logic REG_DECAY   = 1'b1;

  // Commands from the sequencer to the window store
  typedef struct packed {
    logic wr_en;
    logic scan_start;
  } win_cmd_t;

  // Status back from the window store
  typedef struct packed {
    logic busy;
    logic done;
  } win_sts_t;

  // Rise by the decay step, saturate at the field top, then cap at the ceiling.
  function automatic logic signed [LEVEL_W-1:0] rise_capped(
    input logic signed [LEVEL_W-1:0] v,
    input logic [STEP_W-1:0]         step,
    input logic signed [LEVEL_W-1:0] ceil
  );
    logic signed [LEVEL_W:0]   s;
    logic signed [LEVEL_W-1:0] sat;
    s   = {v[LEVEL_W-1], v} + $signed({{(LEVEL_W+1-STEP_W){1'b0}}, step});
    sat = (s > $signed({1'b0, LEVEL_MAX})) ? LEVEL_MAX : s[LEVEL_W-1:0];
    rise_capped = (sat < ceil) ? sat : ceil;
  endfunction

endpackage

// ----- hw/rtl/dmhm_window.sv -----
// Window store of the meter: one synchronous memory and a sequential minimum scan.
// Depends on dmhm_pkg.
`timescale 1ns / 1ps

module dmhm_window
  import dmhm_pkg::*;
#(
  parameter int WIN_LEN = DEF_WINDOW_TICKS + 1,
  parameter int WPW     = $clog2(WIN_LEN),
  parameter int FW      = $clog2(WIN_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  win_cmd_t                  cmd,
  input  logic [WPW-1:0]            wr_addr,
  input  logic signed [LEVEL_W-1:0] wr_data,
  input  logic [FW-1:0]             fill,
  output win_sts_t                  sts,
  output logic signed [LEVEL_W-1:0] scan_min
);

  logic signed [LEVEL_W-1:0] mem [0:WIN_LEN-1];
  logic signed [LEVEL_W-1:0] rd_q;
  logic [FW-1:0]             idx;
  logic                      busy;
  logic                      pend;
  logic                      done;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (busy && (idx != fill)) begin
      rd_q <= mem[idx[WPW-1:0]];
    end
  end

  // scan: issue reads 0..fill-1, fold each one from the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      // last read folded, no read left to issue
      done <= !cmd.scan_start && busy && (idx == fill) && !pend;
      if (cmd.scan_start) begin
        busy     <= 1'b1;
        pend     <= 1'b0;
        idx      <= '0;
        scan_min <= LEVEL_MAX;
      end else if (busy) begin
        if (pend && (rd_q < scan_min)) begin
          scan_min <= rd_q;
        end
        if (idx != fill) begin
          idx  <= idx + 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
          if (!pend) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- hw/rtl/delayed_min_hold_meter_core.sv -----
// Delayed minimum-hold meter: one tick per input transfer, one result transfer per tick.
// A tick runs IDLE, DLY, then SCAN (only with a window update; the scan reads one window
//   entry a cycle), then OUT; no new input transfer is taken until the tick is back in IDLE.
// Reset: ceiling 0, decay step 85, all trackers at the ceiling, input stalled; no clearing.
// Depends on dmhm_pkg, dmhm_window and delayed_min_hold_meter_core_macros.svh.
`timescale 1ns / 1ps
`include "delayed_min_hold_meter_core_macros.svh"

module delayed_min_hold_meter_core
  import dmhm_pkg::*;
#(
  parameter int DELAY_LEN    = DEF_DELAY_LEN,
  parameter int WINDOW_TICKS = DEF_WINDOW_TICKS
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [LEVEL_W-1:0]        cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [LEVEL_W-1:0] level,
  input  logic                      update_window,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [LEVEL_W-1:0] current_min,
  output logic signed [LEVEL_W-1:0] window_min,
  output logic signed [LEVEL_W-1:0] overall_min,
  output logic                      invisible
);

  localparam int WIN_LEN = WINDOW_TICKS + 1;
  localparam int DPW     = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
  localparam int WPW     = $clog2(WIN_LEN);
  localparam int FW      = $clog2(WIN_LEN + 1);

  // Sequencer: IDLE takes a transfer and reads the delay memory, DLY retires the
  // delayed value into the trackers and the window store, SCAN waits for the window
  // minimum, OUT hands the result to the output register.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DLY  = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic signed [LEVEL_W-1:0] ceiling;
  logic [STEP_W-1:0]         step;

  // delay line: memory plus a wrap flag. Before the first wrap since reset or a ceiling
  // write, the entry under the pointer has not been written and reads as the ceiling.
  logic signed [LEVEL_W-1:0] dmem [0:DELAY_LEN-1];
  logic signed [LEVEL_W-1:0] dq;
  logic [DPW-1:0]            delay_pos;
  logic                      dly_wrapped;

  // window bookkeeping
  logic [WPW-1:0] win_pos;
  logic [FW-1:0]  win_fill;

  // trackers
  logic signed [LEVEL_W-1:0] current_hold;
  logic signed [LEVEL_W-1:0] window_hold;
  logic signed [LEVEL_W-1:0] lowest_seen;

  // latched tick
  logic signed [LEVEL_W-1:0] lvl_r;
  logic                      upd_r;

  logic signed [LEVEL_W-1:0] delayed;
  logic signed [LEVEL_W-1:0] scan_min;
  logic                      in_xfer;
  logic                      out_load;
  win_cmd_t                  win_cmd;
  win_sts_t                  win_sts;

  // no transfer is taken while in reset
  assign in_stall = rst || (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign delayed  = dly_wrapped ? dq : ceiling;
  // the output register is free when empty or being drained this cycle
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign win_cmd.wr_en      = (state == S_DLY);
  assign win_cmd.scan_start = (state == S_DLY) && upd_r;

  // delay memory: read on the transfer, write back the new level in DLY
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dq <= dmem[delay_pos];
    end
    if (state == S_DLY) begin
      dmem[delay_pos] <= lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lvl_r <= level;
      upd_r <= update_window;
    end
  end

  // sequencer, configuration and trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ceiling      <= CEIL_RESET;
      step         <= STEP_RESET;
      delay_pos    <= '0;
      dly_wrapped  <= 1'b0;
      win_pos      <= '0;
      win_fill     <= '0;
      current_hold <= CEIL_RESET;
      window_hold  <= CEIL_RESET;
      lowest_seen  <= CEIL_RESET;
    end else begin
      // the user is to write only while idle; the block itself does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          REG_CEILING: begin
            ceiling      <= $signed(cfg_data);
            delay_pos    <= '0;
            dly_wrapped  <= 1'b0;
            win_pos      <= '0;
            win_fill     <= '0;
            current_hold <= $signed(cfg_data);
            window_hold  <= $signed(cfg_data);
            lowest_seen  <= $signed(cfg_data);
          end
          REG_DECAY: begin
            step <= cfg_data[STEP_W-1:0];
          end
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_DLY;
          end
        end
        S_DLY: begin
          if (delay_pos == DPW'(DELAY_LEN - 1)) begin
            delay_pos   <= '0;
            dly_wrapped <= 1'b1;
          end else begin
            delay_pos <= delay_pos + 1'b1;
          end
          // snap down, or rise towards the ceiling
          if (delayed < current_hold) begin
            current_hold <= delayed;
            if (delayed < lowest_seen) begin
              lowest_seen <= delayed;
            end
          end else begin
            current_hold <= rise_capped(current_hold, step, ceiling);
          end
          if (win_pos == WPW'(WIN_LEN - 1)) begin
            win_pos <= '0;
          end else begin
            win_pos <= win_pos + 1'b1;
          end
          if (win_fill != FW'(WIN_LEN)) begin
            win_fill <= win_fill + 1'b1;
          end
          state <= upd_r ? S_SCAN : S_OUT;
        end
        S_SCAN: begin
          if (win_sts.done) begin
            if (scan_min <= window_hold) begin
              window_hold <= scan_min;
            end else begin
              window_hold <= rise_capped(window_hold, step, ceiling);
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register: takes the next result while a finished one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      current_min <= current_hold;
      window_min  <= window_hold;
      overall_min <= lowest_seen;
      invisible   <= (current_hold >= ceiling);
    end
  end

  dmhm_window #(
    .WIN_LEN (WIN_LEN),
    .WPW     (WPW),
    .FW      (FW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .cmd      (win_cmd),
    .wr_addr  (win_pos),
    .wr_data  (delayed),
    .fill     (win_fill),
    .sts      (win_sts),
    .scan_min (scan_min)
  );

  // checks
  `DMHM_ASSERT_NEXT(a_xfer_to_dly, in_xfer, state == S_DLY, "transfer did not start a tick")
  `DMHM_ASSERT_NEXT(a_skip_scan, (state == S_DLY) && !upd_r, state == S_OUT, "scan without request")
  `DMHM_ASSERT_NOW(a_cur_capped, state == S_IDLE, current_hold <= ceiling, "current above ceiling")
  `DMHM_ASSERT_NOW(a_low_le_cur, state == S_IDLE, lowest_seen <= current_hold, "overall above current")
  `DMHM_ASSERT_NOW(a_win_capped, state == S_IDLE, window_hold <= ceiling, "window hold above ceiling")

endmodule
